/* design/sps_pkg.sv */
// Shared types and constants for the song part sequencer.
// Depends on nothing; imported by every module of the block.
package sps_pkg;

    localparam int PC_W      = 10;
    localparam int LEN_W     = 10;
    localparam int FLAG_W    = 8;
    localparam int STEP_W    = 7;
    localparam int WORD_W    = 16;

    localparam logic [STEP_W-1:0] STEP_LIMIT = 7'd100;

    localparam logic [2:0] OP_NOP  = 3'd0;
    localparam logic [2:0] OP_PLAY = 3'd1;
    localparam logic [2:0] OP_SETF = 3'd2;
    localparam logic [2:0] OP_BFEQ = 3'd3;
    localparam logic [2:0] OP_BFNE = 3'd4;
    localparam logic [2:0] OP_JUMP = 3'd5;

    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_RESTART = 2'd1;
    localparam logic [1:0] FUNC_NEXT    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] func;
        logic [8:0] load_address;
        logic [2:0] load_opcode;
        logic [3:0] load_value;
        logic [8:0] load_target;
        logic [7:0] start_flag;
    } t_in_item;

    typedef struct packed {
        logic       play_valid;
        logic [8:0] part_num;
        logic       stopped;
        logic       limit_hit;
    } t_out_item;

    typedef struct packed {
        logic clear_res;
        logic restart;
        logic load;
        logic exec;
        logic halt;
        logic limit;
        logic post;
    } t_cmd;

    typedef struct packed {
        logic at_end;
        logic step_full;
        logic op_play;
        logic halted;
        logic out_free;
    } t_status;

endpackage

/* design/song_part_sequencer_core.sv */
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_stall      i_in_item  (t_in_item)
// out       output     o_out_valid / i_out_stall    o_out_item (t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_data (program length)
//
// A load, an unused item or a request while halted goes straight to posting its result.
// A request executes one instruction after another until it reaches a play or halts,
// paced by the single read port of the program memory, which delivers one instruction
// word per cycle.
// Reset is synchronous and active low; it clears control state but not memory, and no
// item or configuration write is taken while it is held.
// A stalled output holds the result while the next item is already accepted.
// Top level of the song part sequencer; depends on sps_pkg, sps_ctrl and sps_datapath.
module song_part_sequencer_core import sps_pkg::*; #(
    parameter int PROGRAM_DEPTH = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [LEN_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = i_rst_n;

    sps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_item.func),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sps_datapath #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

/* design/sps_ctrl.sv */
// Controller state machine of the song part sequencer.
// Depends on sps_pkg; drives commands into sps_datapath.
module sps_ctrl import sps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_func,
    output logic       o_in_stall,
    input  t_status    i_status,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = !i_rst_n || (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_rst_n) begin
                    o_cmd.clear_res = 1'b1;
                    case (i_func)
                        FUNC_LOAD: begin
                            o_cmd.load = 1'b1;
                            n_state    = S_DONE;
                        end
                        FUNC_RESTART: begin
                            o_cmd.restart = 1'b1;
                            n_state       = S_EXEC;
                        end
                        FUNC_NEXT: begin
                            n_state = i_status.halted ? S_DONE : S_EXEC;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                if (i_status.at_end) begin
                    o_cmd.halt = 1'b1;
                    n_state    = S_DONE;
                end else if (i_status.step_full) begin
                    o_cmd.halt  = 1'b1;
                    o_cmd.limit = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.exec = 1'b1;
                    if (i_status.op_play) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* design/sps_datapath.sv */
// Datapath of the song part sequencer: program memory, counter, flag,
// step count, result and output registers. Depends on sps_pkg.
module sps_datapath import sps_pkg::*; #(
    parameter int PROGRAM_DEPTH = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_item         i_in_item,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    input  logic             i_cfg_valid,
    input  logic [LEN_W-1:0] i_cfg_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item
);

    localparam int AW = $clog2(PROGRAM_DEPTH);

    logic [WORD_W-1:0] mem [PROGRAM_DEPTH];

    logic [LEN_W-1:0]  r_len;
    logic [PC_W-1:0]   r_pc;
    logic [PC_W-1:0]   n_pc;
    logic [FLAG_W-1:0] r_flag;
    logic [FLAG_W-1:0] n_flag;
    logic              r_halted;
    logic [STEP_W-1:0] r_step;
    logic [WORD_W-1:0] r_rdata;
    logic              r_play;
    logic [8:0]        r_part;
    logic              r_limit;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [LEN_W-1:0]  len_eff;
    logic [2:0]        op;
    logic [FLAG_W-1:0] val_ext;
    logic [PC_W-1:0]   tgt_ext;
    logic              wr_ok;

    assign len_eff = (32'(r_len) > PROGRAM_DEPTH) ? LEN_W'(PROGRAM_DEPTH) : r_len;
    assign op      = r_rdata[15:13];
    assign val_ext = FLAG_W'(r_rdata[12:9]);
    assign tgt_ext = PC_W'(r_rdata[8:0]);
    assign wr_ok   = (32'(i_in_item.load_address) < PROGRAM_DEPTH);

    assign o_status.at_end    = (r_pc >= len_eff);
    assign o_status.step_full = (r_step == STEP_LIMIT);
    assign o_status.op_play   = (op == OP_PLAY);
    assign o_status.halted    = r_halted;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_pc   = r_pc;
        n_flag = r_flag;
        if (i_cmd.restart) begin
            n_pc   = '0;
            n_flag = i_in_item.start_flag;
        end else if (i_cmd.halt) begin
            n_pc = len_eff;
        end else if (i_cmd.exec) begin
            n_pc = r_pc + PC_W'(1);
            case (op)
                OP_SETF: begin
                    n_flag = val_ext;
                end
                OP_BFEQ: begin
                    if (r_flag == val_ext) begin
                        n_pc = tgt_ext;
                    end
                end
                OP_BFNE: begin
                    if (r_flag != val_ext) begin
                        n_pc = tgt_ext;
                    end
                end
                OP_JUMP: begin
                    n_pc = tgt_ext;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wr_ok) begin
            mem[AW'(i_in_item.load_address)] <= {i_in_item.load_opcode,
                                                  i_in_item.load_value,
                                                  i_in_item.load_target};
        end
        r_rdata <= mem[AW'(n_pc)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_pc        <= '0;
            r_flag      <= '0;
            r_halted    <= 1'b0;
            r_step      <= '0;
            r_play      <= 1'b0;
            r_part      <= '0;
            r_limit     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_len <= i_cfg_data;
            end
            r_pc   <= n_pc;
            r_flag <= n_flag;
            if (i_cmd.clear_res) begin
                r_step  <= '0;
                r_play  <= 1'b0;
                r_part  <= '0;
                r_limit <= 1'b0;
            end
            if (i_cmd.restart) begin
                r_halted <= 1'b0;
            end
            if (i_cmd.halt) begin
                r_halted <= 1'b1;
                r_limit  <= i_cmd.limit;
            end
            if (i_cmd.exec) begin
                r_step <= r_step + STEP_W'(1);
                if (op == OP_PLAY) begin
                    r_play <= 1'b1;
                    r_part <= r_rdata[8:0];
                end
            end
            if (i_cmd.post) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_out.play_valid <= r_play;
            r_out.part_num   <= r_part;
            r_out.stopped    <= r_halted;
            r_out.limit_hit  <= r_limit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
